>>> hw/rtl/cdll_pkg.sv
// Package for the circular doubly linked list core.
// Sizes, command and status codes, sequencer states. No dependencies.
package cdll_pkg;

   localparam int CAPACITY   = 256;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int COUNT_W    = $clog2(CAPACITY + 1);
   localparam int CMD_W      = 3;
   localparam int STATUS_W   = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_DELETE = 3'd1,
      CMD_FWD    = 3'd2,
      CMD_BWD    = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_LINK = 5'b00100,
      ST_LOAD = 5'b01000,
      ST_FIN  = 5'b10000
   } seq_state_type;

endpackage

>>> hw/rtl/cdll_req_if.sv
// Command channel of the linked list core: valid/ready plus cmd and value.
// Depends on cdll_pkg.
interface cdll_req_if;
   import cdll_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      cmd;
   logic [DATA_WIDTH-1:0] value;
   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

>>> hw/rtl/cdll_rsp_if.sv
// Result channel of the linked list core: valid/ready plus status and list view.
// Depends on cdll_pkg.
interface cdll_rsp_if;
   import cdll_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [DATA_WIDTH-1:0] current_value;
   logic [COUNT_W-1:0]    item_count;
   logic                  list_empty;
   modport source (output valid, output status, output current_value,
                   output item_count, output list_empty, input ready);
   modport sink   (input valid, input status, input current_value,
                   input item_count, input list_empty, output ready);
endinterface

>>> hw/rtl/circular_doubly_linked_list_core.sv
// Top level of the circular doubly linked list core with cursor.
// Depends on cdll_pkg, cdll_req_if, cdll_rsp_if and cdll_ram.
//
//   channel    | dir | handshake    | payload
//   req_chan   | in  | valid/ready  | cmd, value
//   rsp_chan   | out | valid/ready  | status, current_value, item_count, list_empty
//
// One transaction at a time: accept, execute, optional relink or value load, finish.
// The result register lets the next command start while a result waits.
// Reset is synchronous and needs no memory clearing pass.
module circular_doubly_linked_list_core (
   input  logic       clock,
   input  logic       reset,
   cdll_req_if.sink   req_chan,
   cdll_rsp_if.source rsp_chan
);
   import cdll_pkg::*;

   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

   seq_state_type         state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [ADDR_W-1:0]     cursor_ff, cursor_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    free_top_ff, free_top_in;
   logic [COUNT_W-1:0]    fresh_ff, fresh_in;
   logic [ADDR_W-1:0]     slot_ff, slot_in;
   logic [ADDR_W-1:0]     prev_ff, prev_in;
   status_type            status_ff, status_in;
   logic [DATA_WIDTH-1:0] cur_val_ff, cur_val_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                  val_wr_en, fwd_wr_en, bwd_wr_en, free_wr_en;
   logic [ADDR_W-1:0]     val_wr_addr, fwd_wr_addr, bwd_wr_addr, free_wr_addr;
   logic [ADDR_W-1:0]     fwd_wr_data, bwd_wr_data, free_wr_data;
   logic [ADDR_W-1:0]     free_rd_addr;
   logic [DATA_WIDTH-1:0] val_rd_data;
   logic [ADDR_W-1:0]     fwd_rd_data, bwd_rd_data, free_rd_data;
   logic [ADDR_W-1:0]     new_slot;
   logic                  accept;

   assign accept       = req_chan.valid && (state_ff == ST_IDLE);
   assign free_rd_addr = free_top_ff[ADDR_W-1:0] - ADDR_W'(1);
   assign new_slot     = (free_top_ff != '0) ? free_rd_data : fresh_ff[ADDR_W-1:0];

   cdll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_value_ram (
      .clock  (clock),
      .wr_en  (val_wr_en),
      .wr_addr(val_wr_addr),
      .wr_data(val_ff),
      .rd_addr(cursor_in),
      .rd_data(val_rd_data)
   );

   cdll_ram #(.WIDTH(ADDR_W), .DEPTH(CAPACITY)) u_fwd_ram (
      .clock  (clock),
      .wr_en  (fwd_wr_en),
      .wr_addr(fwd_wr_addr),
      .wr_data(fwd_wr_data),
      .rd_addr(cursor_ff),
      .rd_data(fwd_rd_data)
   );

   cdll_ram #(.WIDTH(ADDR_W), .DEPTH(CAPACITY)) u_bwd_ram (
      .clock  (clock),
      .wr_en  (bwd_wr_en),
      .wr_addr(bwd_wr_addr),
      .wr_data(bwd_wr_data),
      .rd_addr(cursor_ff),
      .rd_data(bwd_rd_data)
   );

   cdll_ram #(.WIDTH(ADDR_W), .DEPTH(CAPACITY)) u_free_ram (
      .clock  (clock),
      .wr_en  (free_wr_en),
      .wr_addr(free_wr_addr),
      .wr_data(free_wr_data),
      .rd_addr(free_rd_addr),
      .rd_data(free_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      cursor_in     = cursor_ff;
      count_in      = count_ff;
      free_top_in   = free_top_ff;
      fresh_in      = fresh_ff;
      slot_in       = slot_ff;
      prev_in       = prev_ff;
      status_in     = status_ff;
      cur_val_in    = cur_val_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      val_wr_en     = 1'b0;
      val_wr_addr   = new_slot;
      fwd_wr_en     = 1'b0;
      fwd_wr_addr   = new_slot;
      fwd_wr_data   = new_slot;
      bwd_wr_en     = 1'b0;
      bwd_wr_addr   = new_slot;
      bwd_wr_data   = new_slot;
      free_wr_en    = 1'b0;
      free_wr_addr  = free_top_ff[ADDR_W-1:0];
      free_wr_data  = cursor_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in    = req_chan.cmd;
               val_in    = req_chan.value;
               status_in = STATUS_OK;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FIN;
            case (cmd_ff)
               CMD_INSERT: begin
                  if (count_ff == CAP_COUNT) begin
                     status_in = STATUS_FULL;
                  end else begin
                     if (free_top_ff != '0) begin
                        free_top_in = free_top_ff - COUNT_W'(1);
                     end else begin
                        fresh_in = fresh_ff + COUNT_W'(1);
                     end
                     val_wr_en = 1'b1;
                     fwd_wr_en = 1'b1;
                     bwd_wr_en = 1'b1;
                     slot_in   = new_slot;
                     prev_in   = bwd_rd_data;
                     if (count_ff == '0) begin
                        cursor_in  = new_slot;
                        count_in   = count_ff + COUNT_W'(1);
                        cur_val_in = val_ff;
                     end else begin
                        fwd_wr_data = cursor_ff;
                        bwd_wr_data = bwd_rd_data;
                        state_in    = ST_LINK;
                     end
                  end
               end
               CMD_DELETE: begin
                  if (count_ff != '0) begin
                     free_wr_en  = 1'b1;
                     free_top_in = free_top_ff + COUNT_W'(1);
                     count_in    = count_ff - COUNT_W'(1);
                     if (count_ff == COUNT_W'(1)) begin
                        cursor_in  = '0;
                        cur_val_in = '0;
                     end else begin
                        bwd_wr_en   = 1'b1;
                        bwd_wr_addr = fwd_rd_data;
                        bwd_wr_data = bwd_rd_data;
                        fwd_wr_en   = 1'b1;
                        fwd_wr_addr = bwd_rd_data;
                        fwd_wr_data = fwd_rd_data;
                        cursor_in   = fwd_rd_data;
                        state_in    = ST_LOAD;
                     end
                  end
               end
               CMD_FWD, CMD_BWD: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     cursor_in = (cmd_ff == CMD_FWD) ? fwd_rd_data : bwd_rd_data;
                     state_in  = ST_LOAD;
                  end
               end
               CMD_CLEAR: begin
                  free_top_in = '0;
                  fresh_in    = '0;
                  cursor_in   = '0;
                  count_in    = '0;
                  cur_val_in  = '0;
               end
               default: begin
               end
            endcase
         end
         ST_LINK: begin
            fwd_wr_en   = 1'b1;
            fwd_wr_addr = prev_ff;
            fwd_wr_data = slot_ff;
            bwd_wr_en   = 1'b1;
            bwd_wr_addr = cursor_ff;
            bwd_wr_data = slot_ff;
            cursor_in   = slot_ff;
            count_in    = count_ff + COUNT_W'(1);
            cur_val_in  = val_ff;
            state_in    = ST_FIN;
         end
         ST_LOAD: begin
            cur_val_in = val_rd_data;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = (count_ff == '0) ? '0 : cur_val_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         count_ff     <= '0;
         free_top_ff  <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         count_ff     <= count_in;
         free_top_ff  <= free_top_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      slot_ff       <= slot_in;
      prev_ff       <= prev_in;
      status_ff     <= status_in;
      cur_val_ff    <= cur_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.current_value = rsp_value_ff;
   assign rsp_chan.item_count    = rsp_count_ff;
   assign rsp_chan.list_empty    = (rsp_count_ff == '0);

endmodule

>>> hw/rtl/cdll_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cdll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/cdll_checker.sv
// Port-level assertions for the linked list core, bound to the top level.
// Depends on cdll_pkg and circular_doubly_linked_list_core.
module cdll_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [cdll_pkg::STATUS_W-1:0]   rsp_status,
   input logic [cdll_pkg::DATA_WIDTH-1:0] rsp_current_value,
   input logic [cdll_pkg::COUNT_W-1:0]    rsp_item_count,
   input logic                           rsp_list_empty
);
   import cdll_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_current_value))
      else $error("result dropped or changed while stalled");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item_count <= COUNT_W'(CAPACITY))
      else $error("item count above capacity");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_list_empty == (rsp_item_count == '0)))
      else $error("empty flag disagrees with count");

   a_empty_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_list_empty |-> rsp_current_value == '0
         && rsp_status != STATUS_FULL)
      else $error("empty list shows value or full status");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_item_count == COUNT_W'(CAPACITY))
      else $error("full status below capacity");

endmodule

bind circular_doubly_linked_list_core cdll_checker u_cdll_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_current_value(rsp_chan.current_value),
   .rsp_item_count   (rsp_chan.item_count),
   .rsp_list_empty   (rsp_chan.list_empty)
);
